// File: hw/rtl/vmp_pkg.sv
// ============================================================================
// vmp_pkg: shared constants for the 3-D max pooling block
// Widths, register indexes and small helper functions.
// ============================================================================
`default_nettype none
package vmp_pkg;
    localparam int MAX_DIM    = 64;
    localparam int MAX_KERNEL = 4;
    localparam logic [31:0] NEG_INF_BITS = 32'hFF80_0000;

    localparam logic [2:0] REG_DATA_TYPE = 3'd0;
    localparam logic [2:0] REG_KERNEL    = 3'd1;
    localparam logic [2:0] REG_STRIDE    = 3'd2;
    localparam logic [2:0] REG_DEPTH     = 3'd3;
    localparam logic [2:0] REG_HEIGHT    = 3'd4;
    localparam logic [2:0] REG_WIDTH     = 3'd5;

    function automatic logic is_nan(input logic [31:0] a);
        return a[30:0] > 31'h7F80_0000;
    endfunction

    function automatic logic [31:0] order_key(input logic [31:0] a);
        return a[31] ? ~a : (a | 32'h8000_0000);
    endfunction

    // a > b for non-NaN b, IEEE ordering, signed zeros equal
    function automatic logic float_gt(input logic [31:0] a, input logic [31:0] b);
        logic r;
        if (is_nan(a)) r = 1'b0;
        else if (a[30:0] == 31'd0 && b[30:0] == 31'd0) r = 1'b0;
        else r = order_key(a) > order_key(b);
        return r;
    endfunction
endpackage
`default_nettype wire

// File: hw/rtl/vmp_if.sv
// ============================================================================
// vmp_if: valid/ready channel
// Carries one item of generic payload type.
// ============================================================================
`default_nettype none
interface vmp_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/vmp_ram.sv
// ============================================================================
// vmp_ram: generic single-port-write, one-read RAM
// Registered read.
// ============================================================================
`default_nettype none
module vmp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/volume_max_pool_3d_top.sv
// ============================================================================
// volume_max_pool_3d_top: streaming 3-D max pooling
// Voxel window maxima kept in one RAM, updated read-modify-write.
// ============================================================================
// Usage:
//   s_in carries one voxel sample per item in z,y,x raster order. m_out
//   carries window maxima with grid coordinates; last_of_run marks the final
//   result caused by a voxel. Configuration writes restart the volume.
// Steps: on accept a setup step computes the first window of the voxel; then
//   each window it touches takes a RAM read step and a compare/write step,
//   as the single RAM port pair allows. A voxel covered by no window returns
//   to idle after the setup step.
// One voxel is worked on at a time; the next is accepted once the last
//   window of the current one is written and no register write is under way.
// Reset: registers return to their defaults, position to 0,0,0. Partial
//   maxima need no clearing: each window is written at its origin voxel.
// Stall: a result waits in the output register; the sequencer holds only
//   when its next window update would emit a result before that one is taken.
// ============================================================================
`default_nettype none
module volume_max_pool_3d_top #(
    parameter int MAX_KERNEL = vmp_pkg::MAX_KERNEL,
    localparam int MAX_DIM = vmp_pkg::MAX_DIM,
    localparam int DW = $clog2(MAX_DIM),
    localparam int KW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1,
    localparam int AW = KW + 2 * DW
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [6:0]  i_cfg_wdata,
    vmp_if.sink              s_in,
    vmp_if.source            m_out
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    // configuration
    logic       r_fmode;
    logic [2:0] r_kernel;
    logic [6:0] r_stride, r_depth, r_height, r_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmode <= 1'b0; r_kernel <= 3'd2; r_stride <= 7'd2;
            r_depth <= 7'd64; r_height <= 7'd64; r_width <= 7'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                vmp_pkg::REG_DATA_TYPE: r_fmode  <= i_cfg_wdata[0];
                vmp_pkg::REG_KERNEL:    r_kernel <= i_cfg_wdata[2:0];
                vmp_pkg::REG_STRIDE:    r_stride <= i_cfg_wdata;
                vmp_pkg::REG_DEPTH:     r_depth  <= i_cfg_wdata;
                vmp_pkg::REG_HEIGHT:    r_height <= i_cfg_wdata;
                vmp_pkg::REG_WIDTH:     r_width  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // effective parameters
    function automatic logic [10:0] clampv(input logic [6:0] v, input int hi);
        logic [10:0] r;
        if (v == 7'd0) r = 11'd1;
        else if (11'(v) > 11'(hi)) r = 11'(hi);
        else r = 11'(v);
        return r;
    endfunction

    logic [10:0] k_e, s_e, d_e, h_e, w_e;
    assign k_e = clampv({4'd0, r_kernel}, MAX_KERNEL);
    assign s_e = (r_stride == 7'd0) ? 11'd1 : 11'(r_stride);
    assign d_e = clampv(r_depth, MAX_DIM);
    assign h_e = clampv(r_height, MAX_DIM);
    assign w_e = clampv(r_width, MAX_DIM);

    // position and per-voxel state
    logic [1:0]  r_state;
    logic [10:0] r_pz, r_py, r_px;   // current voxel position
    logic [31:0] r_v;
    // window origins in voxel units: iterate from first to last
    logic [10:0] r_fy, r_fx;         // first origin
    logic [10:0] r_lz, r_ly, r_lx;   // last origin
    logic [10:0] r_cz, r_cy, r_cx;   // current origin
    logic [5:0]  r_gz, r_gy, r_gx;   // grid index of current origin
    logic [5:0]  r_gy0, r_gx0;
    logic        r_ok;               // first window already set up

    // grid index of the largest origin <= position
    logic [5:0]  r_iz, r_iy, r_ix;

    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_rdata, ram_wdata;
    logic          ram_we;

    vmp_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    // output register
    typedef struct packed {
        logic [31:0] max_value;
        logic [5:0]  out_z;
        logic [5:0]  out_y;
        logic [5:0]  out_x;
        logic        last_of_run;
    } t_res;
    logic r_ovalid;
    t_res r_out;
    assign m_out.valid = r_ovalid;
    assign m_out.data  = r_out;

    logic out_free;
    assign out_free = !r_ovalid || m_out.ready;
    assign s_in.ready = (r_state == ST_IDLE) && !i_cfg_we;

    logic accept;
    assign accept = s_in.valid && s_in.ready;

    // address of current window
    assign ram_raddr = {r_gz[KW-1:0], r_gy[DW-1:0], r_gx[DW-1:0]};
    assign ram_waddr = ram_raddr;

    // update datapath
    logic origin, lastwin, emits, at_end, greater, last_res;
    logic [10:0] ez, ey, ex;
    assign origin = (r_pz == r_cz) && (r_py == r_cy) && (r_px == r_cx);
    assign ez = (r_cz + k_e > d_e) ? d_e : r_cz + k_e;
    assign ey = (r_cy + k_e > h_e) ? h_e : r_cy + k_e;
    assign ex = (r_cx + k_e > w_e) ? w_e : r_cx + k_e;
    assign lastwin = (r_pz == ez - 11'd1) && (r_py == ey - 11'd1) && (r_px == ex - 11'd1);
    assign at_end = (r_cz == r_lz) && (r_cy == r_ly) && (r_cx == r_lx);
    // on an axis at the volume edge every covering window ends here, so the
    // final result is the last origin; elsewhere only one origin ends here
    assign last_res = (r_pz != d_e - 11'd1 || r_cz == r_lz)
                   && (r_py != h_e - 11'd1 || r_cy == r_ly)
                   && (r_px != w_e - 11'd1 || r_cx == r_lx);
    assign greater = r_fmode ? vmp_pkg::float_gt(r_v, ram_rdata) : (r_v > ram_rdata);
    always_comb begin
        if (origin)
            ram_wdata = (r_fmode && vmp_pkg::is_nan(r_v)) ? vmp_pkg::NEG_INF_BITS : r_v;
        else
            ram_wdata = greater ? r_v : ram_rdata;
    end
    assign emits  = lastwin;
    assign ram_we = (r_state == ST_UPD) && (!emits || out_free);

    // raster position of the next voxel, with the largest origin per axis
    logic [10:0] r_nz, r_ny, r_nx, r_noz, r_noy, r_nox;
    logic [5:0]  r_niz, r_niy, r_nix;
    logic [10:0] r_rz, r_ry, r_rx;   // residues pos - origin

    // grid of the first window: oi - (number of origins within k-1 below)
    function automatic logic [5:0] back_steps(input logic [10:0] r,
                                              input logic [5:0]  g,
                                              input logic [10:0] s,
                                              input logic [10:0] k);
        // count m>=1 with r + m*s <= k-1 and m <= g, m bounded by MAX_KERNEL-1
        logic [5:0] m;
        m = '0;
        for (int j = 1; j < MAX_KERNEL; j++)
            if (r + 11'(j) * s <= k - 11'd1 && 6'(j) <= g) m = m + 6'd1;
        return m;
    endfunction

    logic [5:0] bz, by, bx;
    assign bz = back_steps(r_rz, r_iz, s_e, k_e);
    assign by = back_steps(r_ry, r_iy, s_e, k_e);
    assign bx = back_steps(r_rx, r_ix, s_e, k_e);

    logic [10:0] mz, my, mx;
    assign mz = 11'(bz) * s_e;
    assign my = 11'(by) * s_e;
    assign mx = 11'(bx) * s_e;

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (ram_we && emits) r_ovalid <= 1'b1;
        else if (m_out.ready) r_ovalid <= 1'b0;
    end

    // position is always inside the volume: writes to registers 0-5 restart it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_nz <= '0; r_ny <= '0; r_nx <= '0;
            r_noz <= '0; r_noy <= '0; r_nox <= '0;
            r_niz <= '0; r_niy <= '0; r_nix <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index <= vmp_pkg::REG_WIDTH) begin
                r_nz <= '0; r_ny <= '0; r_nx <= '0;
                r_noz <= '0; r_noy <= '0; r_nox <= '0;
                r_niz <= '0; r_niy <= '0; r_nix <= '0;
            end
            unique case (r_state)
                ST_IDLE: if (accept) begin
                    r_v <= r_fmode ? s_in.data : {24'd0, s_in.data[7:0]};
                    r_pz <= r_nz; r_py <= r_ny; r_px <= r_nx;
                    r_rz <= r_nz - r_noz; r_ry <= r_ny - r_noy; r_rx <= r_nx - r_nox;
                    r_lz <= r_noz; r_ly <= r_noy; r_lx <= r_nox;
                    r_iz <= r_niz; r_iy <= r_niy; r_ix <= r_nix;
                    r_state <= ST_READ; // setup cycle computes first window
                    r_ok <= 1'b0;
                end
                ST_READ: begin
                    if (!r_ok) begin
                        // first window of this voxel
                        r_ok <= 1'b1;
                        r_fy <= r_ly - my; r_fx <= r_lx - mx;
                        r_cz <= r_lz - mz; r_cy <= r_ly - my; r_cx <= r_lx - mx;
                        r_gz <= r_iz - bz; r_gy <= r_iy - by; r_gx <= r_ix - bx;
                        r_gy0 <= r_iy - by; r_gx0 <= r_ix - bx;
                        // voxel beyond every window
                        if (r_rz >= k_e || r_ry >= k_e || r_rx >= k_e)
                            r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: if (ram_we) begin
                    if (emits) begin
                        r_out.max_value <= ram_wdata;
                        r_out.out_z <= r_gz; r_out.out_y <= r_gy; r_out.out_x <= r_gx;
                        r_out.last_of_run <= last_res;
                    end
                    if (at_end) r_state <= ST_IDLE;
                    else begin
                        r_state <= ST_READ;
                        if (r_cx != r_lx) begin
                            r_cx <= r_cx + s_e; r_gx <= r_gx + 6'd1;
                        end else begin
                            r_cx <= r_fx; r_gx <= r_gx0;
                            if (r_cy != r_ly) begin
                                r_cy <= r_cy + s_e; r_gy <= r_gy + 6'd1;
                            end else begin
                                r_cy <= r_fy; r_gy <= r_gy0;
                                r_cz <= r_cz + s_e; r_gz <= r_gz + 6'd1;
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            // advance raster position and largest origin on accept
            if (accept) begin
                if (r_nx + 11'd1 < w_e) begin
                    r_nx <= r_nx + 11'd1;
                    if (r_nx + 11'd1 == r_nox + s_e) begin
                        r_nox <= r_nox + s_e; r_nix <= r_nix + 6'd1;
                    end
                end else begin
                    r_nx <= '0; r_nox <= '0; r_nix <= '0;
                    if (r_ny + 11'd1 < h_e) begin
                        r_ny <= r_ny + 11'd1;
                        if (r_ny + 11'd1 == r_noy + s_e) begin
                            r_noy <= r_noy + s_e; r_niy <= r_niy + 6'd1;
                        end
                    end else begin
                        r_ny <= '0; r_noy <= '0; r_niy <= '0;
                        if (r_nz + 11'd1 < d_e) begin
                            r_nz <= r_nz + 11'd1;
                            if (r_nz + 11'd1 == r_noz + s_e) begin
                                r_noz <= r_noz + s_e; r_niz <= r_niz + 6'd1;
                            end
                        end else begin
                            r_nz <= '0; r_noz <= '0; r_niz <= '0;
                        end
                    end
                end
            end
        end
    end

`ifndef SYNTHESIS
    // a result is only produced while a window update is written
    a_out_from_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == ST_UPD) else $error("stray result");
    // no new voxel while windows are still being updated
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_in.ready) else $error("overlap");
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_out.ready) |=> $stable(r_out)) else $error("result changed");
`endif
endmodule
`default_nettype wire

// File: test/tb_top.sv
// ============================================================================
// tb_top: self-checking testbench for volume_max_pool_3d_top
// Streams voxels through the pooling block under a series of register
// settings, predicts every window maximum in the bench, and checks each
// result field by field, with random gaps on the input and random stalls
// on the output.
// ============================================================================
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Unused register slots; writes there must be ignored
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;
    localparam int SETTLE_CYCLES = 200;
    localparam int GRID_SLOTS    = vmp_pkg::MAX_KERNEL * vmp_pkg::MAX_DIM * vmp_pkg::MAX_DIM;

    typedef struct packed {
        logic [31:0] sample;
    } t_voxel;

    typedef struct packed {
        logic [31:0] max_value;
        logic [5:0]  out_z;
        logic [5:0]  out_y;
        logic [5:0]  out_x;
        logic        last_of_run;
    } t_pool_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [2:0] i_cfg_index = '0;
    logic [6:0] i_cfg_wdata = '0;

    vmp_if #(.T(t_voxel))       voxel_ch ();
    vmp_if #(.T(t_pool_result)) result_ch ();

    volume_max_pool_3d_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .s_in        (voxel_ch),
        .m_out       (result_ch)
    );

    always #5 i_clk = ~i_clk;

    // Bench copy of the registers and the pooling state
    logic        cfg_float;
    logic [2:0]  cfg_kernel;
    logic [6:0]  cfg_stride, cfg_depth, cfg_height, cfg_width;
    logic [31:0] window_max [GRID_SLOTS];
    int          at_z, at_y, at_x;

    logic [31:0]  voxel_q [$];
    t_pool_result expected_max_q [$];
    logic         burst_mode = 1'b0;
    int           mismatches = 0;
    int           results_seen = 0;
    int           voxels_sent = 0;
    int           phases_run = 0;

    function automatic int clip_dim(input int v, input int hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic int lowest_origin(input int p, input int k, input int s);
        if (p + 1 < k) return 0;
        return (p + 1 - k + s - 1) / s;
    endfunction

    function automatic int window_end(input int o, input int k, input int s,
                                      input int dim);
        int e;
        e = o * s + k;
        if (e > dim) e = dim;
        return e - 1;
    endfunction

    // Float ordering: true when a is strictly larger than b (b never NaN)
    function automatic logic float_wins(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ka, kb;
        if (a[30:23] == 8'hFF && a[22:0] != 0) return 1'b0;
        if (a[30:0] == 0 && b[30:0] == 0) return 1'b0;
        ka = a[31] ? ~a : {1'b1, a[30:0]};
        kb = b[31] ? ~b : {1'b1, b[30:0]};
        return ka > kb;
    endfunction

    // Update open windows for one voxel and queue the finished maxima
    task automatic pool_voxel(input logic [31:0] raw);
        int k, s, d, h, w, oz, oy, ox, idx, n;
        logic [31:0] v;
        logic        origin;
        t_pool_result r;
        k = clip_dim(int'(cfg_kernel), vmp_pkg::MAX_KERNEL);
        s = (cfg_stride == 0) ? 1 : int'(cfg_stride);
        d = clip_dim(int'(cfg_depth), vmp_pkg::MAX_DIM);
        h = clip_dim(int'(cfg_height), vmp_pkg::MAX_DIM);
        w = clip_dim(int'(cfg_width), vmp_pkg::MAX_DIM);
        v = cfg_float ? raw : {24'd0, raw[7:0]};
        n = 0;
        if (at_z >= d || at_y >= h || at_x >= w) begin
            at_z = 0; at_y = 0; at_x = 0;
        end
        for (oz = lowest_origin(at_z, k, s); oz <= at_z / s; oz++)
            for (oy = lowest_origin(at_y, k, s); oy <= at_y / s; oy++)
                for (ox = lowest_origin(at_x, k, s); ox <= at_x / s; ox++) begin
                    idx = (oz % vmp_pkg::MAX_KERNEL) * vmp_pkg::MAX_DIM * vmp_pkg::MAX_DIM
                        + (oy % vmp_pkg::MAX_DIM) * vmp_pkg::MAX_DIM
                        + (ox % vmp_pkg::MAX_DIM);
                    origin = (at_z == oz * s) && (at_y == oy * s) && (at_x == ox * s);
                    if (origin) begin
                        if (cfg_float && v[30:23] == 8'hFF && v[22:0] != 0)
                            window_max[idx] = vmp_pkg::NEG_INF_BITS;
                        else
                            window_max[idx] = v;
                    end else if (cfg_float) begin
                        if (float_wins(v, window_max[idx])) window_max[idx] = v;
                    end else if (v > window_max[idx]) begin
                        window_max[idx] = v;
                    end
                    if (at_z == window_end(oz, k, s, d) && at_y == window_end(oy, k, s, h)
                            && at_x == window_end(ox, k, s, w)) begin
                        r.max_value   = window_max[idx];
                        r.out_z       = oz[5:0];
                        r.out_y       = oy[5:0];
                        r.out_x       = ox[5:0];
                        r.last_of_run = 1'b0;
                        expected_max_q.push_back(r);
                        n++;
                    end
                end
        if (n > 0) expected_max_q[expected_max_q.size() - 1].last_of_run = 1'b1;
        at_x++;
        if (at_x >= w) begin
            at_x = 0;
            at_y++;
            if (at_y >= h) begin
                at_y = 0;
                at_z++;
                if (at_z >= d) at_z = 0;
            end
        end
    endtask

    // Voxel driver: gap drawn per item, one assignment per signal per edge
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            voxel_ch.valid <= 1'b0;
            voxel_ch.data  <= '0;
            gap_left       <= 0;
        end else if (!voxel_ch.valid || voxel_ch.ready) begin
            if (voxel_ch.valid) begin
                pool_voxel(voxel_ch.data.sample);
                voxels_sent++;
            end
            if (gap_left > 0) begin
                voxel_ch.valid <= 1'b0;
                gap_left       <= gap_left - 1;
            end else if (voxel_q.size() > 0) begin
                voxel_ch.valid       <= 1'b1;
                voxel_ch.data.sample <= voxel_q.pop_front();
                gap_left             <= burst_mode ? 0 : $urandom_range(0, 4);
            end else begin
                voxel_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor with random stalls
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_pool_result want, got;
        int           next_stall;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            stall_left      <= 0;
        end else begin
            next_stall = stall_left;
            if (result_ch.valid && result_ch.ready) begin
                got = result_ch.data;
                results_seen++;
                if (expected_max_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result max=%h z=%0d y=%0d x=%0d last=%b",
                                 got.max_value, got.out_z, got.out_y, got.out_x,
                                 got.last_of_run);
                end else begin
                    want = expected_max_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: result %0d exp max=%h z=%0d y=%0d x=%0d last=%b, got max=%h z=%0d y=%0d x=%0d last=%b",
                                     results_seen, want.max_value, want.out_z, want.out_y,
                                     want.out_x, want.last_of_run, got.max_value, got.out_z,
                                     got.out_y, got.out_x, got.last_of_run);
                    end
                end
                next_stall = burst_mode ? 0 : $urandom_range(0, 4);
            end
            if (next_stall > 0) begin
                result_ch.ready <= 1'b0;
                stall_left      <= next_stall - 1;
            end else begin
                result_ch.ready <= 1'b1;
                stall_left      <= 0;
            end
        end
    end

    // Register write; for indexes 0 to 5 the bench copy tracks it and restarts the volume
    task automatic write_reg(input logic [2:0] idx, input logic [6:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            vmp_pkg::REG_DATA_TYPE: cfg_float  = val[0];
            vmp_pkg::REG_KERNEL:    cfg_kernel = val[2:0];
            vmp_pkg::REG_STRIDE:    cfg_stride = val;
            vmp_pkg::REG_DEPTH:     cfg_depth  = val;
            vmp_pkg::REG_HEIGHT:    cfg_height = val;
            vmp_pkg::REG_WIDTH:     cfg_width  = val;
            default:                return;
        endcase
        at_z = 0; at_y = 0; at_x = 0;
    endtask

    task automatic setup(input logic dt, input int k, input int s,
                         input int d, input int h, input int w);
        write_reg(vmp_pkg::REG_DATA_TYPE, 7'(dt));
        write_reg(vmp_pkg::REG_KERNEL, 7'(k));
        write_reg(vmp_pkg::REG_STRIDE, 7'(s));
        write_reg(vmp_pkg::REG_DEPTH, 7'(d));
        write_reg(vmp_pkg::REG_HEIGHT, 7'(h));
        write_reg(vmp_pkg::REG_WIDTH, 7'(w));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_sample(input logic fl);
        logic [31:0] specials [10];
        specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'h0000_0001,
                     32'h7F7F_FFFF, 32'hFF7F_FFFF};
        if (fl && $urandom_range(0, 3) == 0) return specials[$urandom_range(0, 9)];
        return $urandom();
    endfunction

    // Wait until the block has drained, then let it settle
    task automatic drain();
        do @(posedge i_clk);
        while (voxel_q.size() != 0 || voxel_ch.valid || expected_max_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        phases_run++;
    endtask

    task automatic run_random(input int count);
        logic fl;
        fl = cfg_float;
        repeat (count) voxel_q.push_back(pick_sample(fl));
        drain();
    endtask

    initial begin
        int d, h, w, vol, total;
        cfg_float = 1'b0; cfg_kernel = 3'd2; cfg_stride = 7'd2;
        cfg_depth = 7'd64; cfg_height = 7'd64; cfg_width = 7'd64;
        at_z = 0; at_y = 0; at_x = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: byte extremes on a 2x2x3 volume, k2 s2 (clipped windows)
        setup(1'b0, 2, 2, 2, 2, 3);
        voxel_q = '{32'h0, 32'hFF, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'h80, 32'h7F,
                    32'h1, 32'hFE, 32'h0, 32'h55, 32'hAA, 32'h0};
        drain();
        // Float specials: signed zeros, infinities, NaNs that must never win
        setup(1'b1, 2, 1, 1, 2, 2);
        voxel_q = '{32'h7FC0_0000, 32'h8000_0000, 32'h0000_0000, 32'hFF80_0000,
                    32'h7F80_0001, 32'hFFC0_0000, 32'hFF80_0000, 32'h7F80_0000};
        drain();
        // Spare register indexes are ignored; out-of-range kernel/size/stride
        write_reg(REG_SPARE_A, 7'h7F);
        write_reg(REG_SPARE_B, 7'h00);
        setup(1'b0, 7, 0, 0, 127, 0);
        run_random(70);
        // Zero kernel, stride beyond kernel (uncovered voxels)
        setup(1'b0, 0, 3, 2, 4, 5);
        run_random(40);
        // Largest result burst: every window ends on the last voxel
        setup(1'b1, 4, 1, 4, 4, 4);
        run_random(64);
        // Extreme stride and widest row
        setup(1'b0, 4, 64, 1, 1, 64);
        run_random(64);

        // Random settings, small volumes, some with a partial volume
        total = 0;
        while (total < 240) begin
            d = $urandom_range(1, 4);
            h = $urandom_range(1, 5);
            w = $urandom_range(1, 6);
            burst_mode = ($urandom_range(0, 3) == 0);
            setup(1'($urandom_range(0, 1)), $urandom_range(0, 5), $urandom_range(0, 5),
                  d, h, w);
            vol = d * h * w;
            vol = vol * $urandom_range(1, 2) + $urandom_range(0, vol - 1);
            if (vol > 80) vol = 80;
            run_random(vol);
            total += vol;
        end
        burst_mode = 1'b0;

        $display("Covered %0d voxels in %0d register settings, %0d window maxima checked.",
                 voxels_sent, phases_run, results_seen);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout with %0d results outstanding", expected_max_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
hw/rtl/vmp_pkg.sv
hw/rtl/vmp_if.sv
hw/rtl/vmp_ram.sv
hw/rtl/volume_max_pool_3d_top.sv
test/tb_top.sv
